### src/pvs_pkg.sv
// Package for the perspective vertex to screen core.
// Holds register codes, reset values and fixed-point constants; no dependencies.
`default_nettype none
package pvs_pkg;

    localparam int COEFF_WIDTH_DEF = 16;
    localparam int LANE_W          = 16;
    localparam int WORLD_W         = 32;
    localparam int SCREEN_W        = 24;
    localparam int SIZE_W          = 14;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 6;
    localparam int REG_IDX_W       = 3;

    localparam int W_MIN    = 26844;
    localparam int DIV_FRAC = 24;
    localparam int Q_INT    = 16;
    localparam int Q_W      = DIV_FRAC + Q_INT;
    localparam int CONST_SHIFT = 16;
    localparam int SIZE_SHIFT  = 7;
    localparam int M_W         = SIZE_W + SIZE_SHIFT;

    localparam logic [REG_IDX_W-1:0] REG_COL_X  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COL_Y  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COL_W  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;

    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } side_t;

endpackage
`default_nettype wire

### src/pvs_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pvs_pkg for the quotient format.
`default_nettype none
module pvs_divider #(
    parameter int DW = 51
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DW-1:0]        a_in,
    input  wire logic [DW-1:0]        w_in,
    output logic [pvs_pkg::Q_W-1:0]   q_out
);
    import pvs_pkg::*;

    logic [DW-1:0]    r_reg [Q_W];
    logic [DW-1:0]    w_reg [Q_W];
    logic [Q_INT-1:0] a_reg [Q_W];
    logic [Q_W-1:0]   q_reg [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_stage
            logic [DW-1:0]    r_prev;
            logic [DW-1:0]    w_prev;
            logic [Q_INT-1:0] a_prev;
            logic [Q_W-1:0]   q_prev;
            logic [DW-1:0]    r_sh;
            logic             ge;
            if (k == 0)
            begin : g_first
                assign r_prev = a_in >> Q_INT;
                assign w_prev = w_in;
                assign a_prev = a_in[Q_INT-1:0];
                assign q_prev = '0;
            end
            else
            begin : g_rest
                assign r_prev = r_reg[k-1];
                assign w_prev = w_reg[k-1];
                assign a_prev = a_reg[k-1];
                assign q_prev = q_reg[k-1];
            end
            assign r_sh = {r_prev[DW-2:0], (k < Q_INT) ? a_prev[Q_INT-1] : 1'b0};
            assign ge   = (r_sh >= w_prev);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= ge ? (r_sh - w_prev) : r_sh;
                    w_reg[k] <= w_prev;
                    a_reg[k] <= {a_prev[Q_INT-2:0], 1'b0};
                    q_reg[k] <= {q_prev[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign q_out = q_reg[Q_W-1];

endmodule
`default_nettype wire

### src/perspective_vertex_to_screen_core.sv
// Top level of the perspective vertex to screen core.
// Depends on pvs_pkg and pvs_divider.
//
// Usage:
//   s_* carries one world point per transfer (x, y, z in Q16.16).
//   m_* returns screen x and y (Q16.8, saturated) and a visible flag.
//   The APB port writes the three coefficient columns and display size;
//   write only while no point is in flight.
// Throughput: one point per cycle unless m_tready stalls the output;
//   the pipeline is 4 arithmetic stages, 40 divider stages (one quotient
//   bit each), a multiply and a clamp stage.
// Reset: all valid bits clear, columns are zero, display is 1920 x 1080.
// Stall: when the result waits and m_tready is low, the whole pipeline
//   holds and s_tready drops; nothing is lost or repeated.
`default_nettype none
module perspective_vertex_to_screen_core #(
    parameter int COEFF_WIDTH = pvs_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [95:0]                   s_tdata,  // world_x, world_y, world_z
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,  // screen_x, screen_y
    output logic [0:0]                         m_tuser,  // visible
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pvs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pvs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pvs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import pvs_pkg::*;

    localparam int PROD_W = WORLD_W + COEFF_WIDTH;
    localparam int CLIP_W = PROD_W + 2;
    localparam int N_W    = CLIP_W + 1;
    localparam int MUL_W  = Q_W + M_W;
    localparam int RND_W  = MUL_W + 1;

    // configuration
    logic [CFG_DATA_W-1:0] col_x_reg, col_y_reg, col_w_reg;
    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic [REG_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_x_reg  <= '0;
            col_y_reg  <= '0;
            col_w_reg  <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_idx)
                REG_COL_X:  col_x_reg  <= pwdata;
                REG_COL_Y:  col_y_reg  <= pwdata;
                REG_COL_W:  col_w_reg  <= pwdata;
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_COL_X:  prdata = col_x_reg;
            REG_COL_Y:  prdata = col_y_reg;
            REG_COL_W:  prdata = col_w_reg;
            REG_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // coefficient lanes
    logic signed [COEFF_WIDTH-1:0] cx_l [4];
    logic signed [COEFF_WIDTH-1:0] cy_l [4];
    logic signed [COEFF_WIDTH-1:0] cw_l [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cx_l[i] = col_x_reg[LANE_W*i +: COEFF_WIDTH];
            cy_l[i] = col_y_reg[LANE_W*i +: COEFF_WIDTH];
            cw_l[i] = col_w_reg[LANE_W*i +: COEFF_WIDTH];
        end
    end

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: products
    logic signed [WORLD_W-1:0] wx, wy, wz;
    logic                      v1_reg;
    logic signed [PROD_W-1:0]  px_reg [3];
    logic signed [PROD_W-1:0]  py_reg [3];
    logic signed [PROD_W-1:0]  pw_reg [3];

    assign wx = s_tdata[31:0];
    assign wy = s_tdata[63:32];
    assign wz = s_tdata[95:64];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= wx * cx_l[0];
            px_reg[1] <= wy * cx_l[1];
            px_reg[2] <= wz * cx_l[2];
            py_reg[0] <= wx * cy_l[0];
            py_reg[1] <= wy * cy_l[1];
            py_reg[2] <= wz * cy_l[2];
            pw_reg[0] <= wx * cw_l[0];
            pw_reg[1] <= wy * cw_l[1];
            pw_reg[2] <= wz * cw_l[2];
        end
    end

    // stage 2: clip sums
    logic signed [PROD_W-1:0] kx, ky, kw;
    logic signed [CLIP_W-1:0] clx_reg, cly_reg, clw_reg;
    logic                     v2_reg;

    assign kx = PROD_W'(cx_l[3]) <<< CONST_SHIFT;
    assign ky = PROD_W'(cy_l[3]) <<< CONST_SHIFT;
    assign kw = PROD_W'(cw_l[3]) <<< CONST_SHIFT;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clx_reg <= CLIP_W'(px_reg[0]) + CLIP_W'(px_reg[1])
                     + CLIP_W'(px_reg[2]) + CLIP_W'(kx);
            cly_reg <= CLIP_W'(py_reg[0]) + CLIP_W'(py_reg[1])
                     + CLIP_W'(py_reg[2]) + CLIP_W'(ky);
            clw_reg <= CLIP_W'(pw_reg[0]) + CLIP_W'(pw_reg[1])
                     + CLIP_W'(pw_reg[2]) + CLIP_W'(kw);
        end
    end

    // stage 3: numerators and visibility
    logic signed [N_W-1:0] nx_reg, ny_reg;
    logic [N_W-1:0]        w3_reg;
    logic                  vis3_reg;
    logic                  v3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg   <= N_W'(clx_reg) + N_W'(clw_reg);
            ny_reg   <= N_W'(clw_reg) - N_W'(cly_reg);
            w3_reg   <= N_W'(clw_reg);
            vis3_reg <= (clw_reg > W_MIN);
        end
    end

    // stage 4: magnitudes
    logic [N_W-1:0] ax_reg, ay_reg, w4_reg;
    logic           negx_reg, negy_reg, vis4_reg;
    logic           v4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg   <= nx_reg[N_W-1] ? (N_W'(0) - nx_reg) : nx_reg;
            ay_reg   <= ny_reg[N_W-1] ? (N_W'(0) - ny_reg) : ny_reg;
            negx_reg <= nx_reg[N_W-1];
            negy_reg <= ny_reg[N_W-1];
            w4_reg   <= w3_reg;
            vis4_reg <= vis3_reg;
        end
    end

    // divider and sideband line
    logic [N_W+Q_INT-1:0] w_sh;
    side_t                side_in;
    side_t                side_reg [Q_W];
    logic                 dv_reg   [Q_W];
    logic [Q_W-1:0]       qx, qy;

    assign w_sh = {w4_reg, {Q_INT{1'b0}}};

    always_comb
    begin
        side_in.vis   = vis4_reg;
        side_in.neg_x = negx_reg;
        side_in.neg_y = negy_reg;
        side_in.ovf_x = ({{Q_INT{1'b0}}, ax_reg} >= w_sh);
        side_in.ovf_y = ({{Q_INT{1'b0}}, ay_reg} >= w_sh);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < Q_W; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    pvs_divider #(.DW(N_W)) u_div_x (
        .clk   (clk),
        .en    (adv),
        .a_in  (ax_reg),
        .w_in  (w4_reg),
        .q_out (qx)
    );

    pvs_divider #(.DW(N_W)) u_div_y (
        .clk   (clk),
        .en    (adv),
        .a_in  (ay_reg),
        .w_in  (w4_reg),
        .q_out (qy)
    );

    // multiply by viewport scale
    logic [M_W-1:0]   mx, my;
    logic [MUL_W-1:0] prx_reg, pry_reg;
    logic             mx_zero_reg, my_zero_reg;
    side_t            side_m_reg;
    logic             vm_reg;

    assign mx = {width_reg, {SIZE_SHIFT{1'b0}}};
    assign my = {height_reg, {SIZE_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prx_reg     <= MUL_W'(qx) * MUL_W'(mx);
            pry_reg     <= MUL_W'(qy) * MUL_W'(my);
            mx_zero_reg <= (width_reg == '0);
            my_zero_reg <= (height_reg == '0);
            side_m_reg  <= side_reg[Q_W-1];
        end
    end

    // round, saturate and sign
    localparam logic [RND_W-1:0] HALF = RND_W'(1) << (DIV_FRAC - 1);
    localparam int               MAG_W = RND_W - DIV_FRAC;
    localparam logic [MAG_W-1:0] CAP   = MAG_W'(1) << SCREEN_W;
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (SCREEN_W - 1);
    localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

    function automatic logic [SCREEN_W-1:0] finish(
        input logic [MUL_W-1:0] prod,
        input logic             ovf,
        input logic             neg,
        input logic             zero
    );
        logic [RND_W-1:0] rnd;
        logic [MAG_W-1:0] mag;
        logic [SCREEN_W-1:0] res;
        rnd = RND_W'(prod) + HALF;
        mag = rnd[RND_W-1:DIV_FRAC];
        if (ovf || mag > CAP)
            mag = CAP;
        else if (zero)
            mag = '0;
        if (neg)
            res = (mag > NEG_LIM) ? NEG_LIM[SCREEN_W-1:0] : (SCREEN_W'(0) - mag[SCREEN_W-1:0]);
        else
            res = (mag > POS_LIM) ? POS_LIM[SCREEN_W-1:0] : mag[SCREEN_W-1:0];
        return res;
    endfunction

    logic [SCREEN_W-1:0] sx_reg, sy_reg;
    logic                vis_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= side_m_reg.vis;
            sx_reg  <= side_m_reg.vis ?
                       finish(prx_reg, side_m_reg.ovf_x, side_m_reg.neg_x, mx_zero_reg) : '0;
            sy_reg  <= side_m_reg.vis ?
                       finish(pry_reg, side_m_reg.ovf_y, side_m_reg.neg_y, my_zero_reg) : '0;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < Q_W; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int i = 1; i < Q_W; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            vm_reg        <= dv_reg[Q_W-1];
            out_valid_reg <= vm_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sy_reg, sx_reg};
    assign m_tuser  = vis_reg;

endmodule
`default_nettype wire

### test/perspective_vertex_to_screen_core_test.sv
// Testbench for perspective_vertex_to_screen_core: drives world points over the stream port,
// predicts screen x/y and visibility in fixed point and checks every result transfer.
// Depends on pvs_pkg and the core RTL only.
`timescale 1ns / 1ps
module perspective_vertex_to_screen_core_test;
    import pvs_pkg::*;

    typedef struct packed {
        logic [23:0] sy;
        logic [23:0] sx;
        logic        vis;
    } screen_pt_t;

    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        bit          known;
        screen_pt_t  res;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;   // world_x, world_y, world_z
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;        // screen_x, screen_y
    logic [0:0] m_tuser;         // visible
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    perspective_vertex_to_screen_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [63:0] col_x, col_y, col_w;
    logic [13:0] disp_w, disp_h;
    screen_pt_t  screen_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          sink_wait = 0;
    bit          long_hold = 1'b0;
    bit          done = 1'b0;

    function automatic longint lane_coeff(logic [63:0] col, int lane);
        logic [15:0] v;
        v = col[16*lane +: 16];
        return longint'($signed(v));
    endfunction

    function automatic longint clip_value(logic [63:0] col, longint x, longint y, longint z);
        return x * lane_coeff(col, 0) + y * lane_coeff(col, 1) + z * lane_coeff(col, 2)
            + lane_coeff(col, 3) * 65536;
    endfunction

    function automatic logic [23:0] map_axis(longint n, longint w, logic [13:0] sz);
        logic [63:0] a, q, r, t, m, mag;
        longint res;
        a = (n < 0) ? 64'(-n) : 64'(n);
        m = 64'(sz) * 128;
        q = a / 64'(w);
        if (q >= 65536)
            mag = 64'd1 << 24;
        else
        begin
            r = a % 64'(w);
            t = q;
            for (int i = 0; i < DIV_FRAC; i++)
            begin
                r = r << 1;
                t = t << 1;
                if (r >= 64'(w))
                begin
                    r = r - 64'(w);
                    t[0] = 1'b1;
                end
            end
            mag = (t * m + (64'd1 << 23)) >> 24;
            if (mag > (64'd1 << 24))
                mag = 64'd1 << 24;
        end
        if (n < 0)
            res = (mag > 8388608) ? -8388608 : -longint'(mag);
        else
            res = (mag > 8388607) ? 8388607 : longint'(mag);
        return res[23:0];
    endfunction

    function automatic screen_pt_t project_point(logic [31:0] wx, logic [31:0] wy,
                                                 logic [31:0] wz);
        longint x, y, z, cx, cy, cw;
        screen_pt_t p;
        x = longint'($signed(wx));
        y = longint'($signed(wy));
        z = longint'($signed(wz));
        cx = clip_value(col_x, x, y, z);
        cy = clip_value(col_y, x, y, z);
        cw = clip_value(col_w, x, y, z);
        p = '0;
        if (cw > W_MIN)
        begin
            p.sx = map_axis(cx + cw, cw, disp_w);
            p.sy = map_axis(cw - cy, cw, disp_h);
            p.vis = 1'b1;
        end
        return p;
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CFG_ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COL_X:  col_x = value;
            REG_COL_Y:  col_y = value;
            REG_COL_W:  col_w = value;
            REG_WIDTH:  disp_w = value[13:0];
            REG_HEIGHT: disp_h = value[13:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        while (screen_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {wz, wy, wx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        screen_q.push_back(project_point(wx, wy, wz));
    endtask

    function automatic logic [63:0] rand_col();
        return {$urandom(), $urandom()};
    endfunction

    // Sink: random stalls, one long hold-off on request.
    always @(posedge clk)
    begin
        int w;
        w = $urandom_range(0, 12);
        if (long_hold)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            m_tready <= (w == 0);
            sink_wait <= w;
        end
        else if (sink_wait > 1)
            sink_wait <= sink_wait - 1;
        else
        begin
            m_tready <= 1'b1;
            sink_wait <= 0;
        end
    end

    always @(posedge clk)
    begin
        screen_pt_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sx = m_tdata[23:0];
            got.sy = m_tdata[47:24];
            got.vis = m_tuser[0];
            if (screen_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = screen_q.pop_front();
                if (got.sx !== want.sx)
                begin
                    $display("%0t screen_x exp %h got %h", $time, want.sx, got.sx);
                    errors++;
                end
                if (got.sy !== want.sy)
                begin
                    $display("%0t screen_y exp %h got %h", $time, want.sy, got.sy);
                    errors++;
                end
                if (got.vis !== want.vis)
                begin
                    $display("%0t visible exp %b got %b", $time, want.vis, got.vis);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000 && !done)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    point_row_t rows[$];

    task automatic directed_rows(bit at_reset);
        point_row_t r;
        r.known = at_reset;
        r.res = '0;
        // reset columns: w is zero, not visible
        r.wx = 32'h7FFF_FFFF; r.wy = 32'h8000_0000; r.wz = 32'h0001_0000; rows.push_back(r);
        r.wx = 0; r.wy = 0; r.wz = 0; rows.push_back(r);
        r.known = 1'b0;
        r.wx = 32'h8000_0000; r.wy = 32'h7FFF_FFFF; r.wz = 32'hFFFF_FFFF; rows.push_back(r);
        r.wx = 32'h0001_0000; r.wy = 32'hFFFF_0000; r.wz = 32'h0002_0000; rows.push_back(r);
        r.wx = 32'h0000_8000; r.wy = 32'h0000_4000; r.wz = 32'h0010_0000; rows.push_back(r);
        r.wx = 32'hFFFF_FFFF; r.wy = 32'h0000_0001; r.wz = 32'h8000_0000; rows.push_back(r);
        r.wx = 32'h0000_0000; r.wy = 32'h0000_0000; r.wz = 32'h7FFF_FFFF; rows.push_back(r);
        r.wx = 32'h5555_5555; r.wy = 32'hAAAA_AAAA; r.wz = 32'h0000_0001; rows.push_back(r);
    endtask

    task automatic run_rows;
        foreach (rows[i])
        begin
            send_point(rows[i].wx, rows[i].wy, rows[i].wz);
            if (rows[i].known && screen_q[$] !== rows[i].res)
            begin
                $display("%0t table row %0d exp %h pred %h", $time, i, rows[i].res,
                         screen_q[$]);
                errors++;
            end
        end
        s_tvalid <= 1'b0;
        rows.delete();
    endtask

    task automatic random_points(int count, bit narrow);
        logic [31:0] v [3];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 3; k++)
                v[k] = narrow ? 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000)
                              : $urandom();
            if (!narrow && $urandom_range(0, 9) == 0)
                v[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF
                                                                      : 32'h8000_0000;
            send_point(v[0], v[1], v[2]);
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        col_x = '0; col_y = '0; col_w = '0;
        disp_w = WIDTH_RESET;
        disp_h = HEIGHT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows(1'b1);
        rows[0].known = 1'b1;
        rows.delete(7);
        rows.delete(6);
        rows.delete(5);
        rows.delete(4);
        rows.delete(3);
        rows.delete(2);
        run_rows();
        drain();

        // identity-like projection: x, y pass, w = z
        write_reg(REG_COL_X, 64'h0000_0000_0000_1000);
        write_reg(REG_COL_Y, 64'h0000_0000_1000_0000);
        write_reg(REG_COL_W, 64'h0000_1000_0000_0000);
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
        directed_rows(1'b0);
        run_rows();
        drain();

        // extreme coefficients, out-of-range sizes
        write_reg(REG_COL_X, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_COL_Y, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_COL_W, 64'h0001_0000_0000_FFFF);
        write_reg(REG_WIDTH, 64'hFFFF_FFFF_FFFF_0000);
        write_reg(REG_HEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
        directed_rows(1'b0);
        run_rows();
        drain();
        write_reg(3'd7, 64'hDEAD_BEEF_0000_0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_COL_X, (phase % 2) ? rand_col()
                                 : {16'($urandom_range(0, 16'hFFFF)), 48'h0000_0000_1000});
            write_reg(REG_COL_Y, (phase % 2) ? rand_col()
                                 : {16'($urandom_range(0, 16'hFFFF)), 48'h0000_1000_0000});
            write_reg(REG_COL_W, (phase % 2) ? rand_col()
                                 : {16'($urandom_range(16'h0100, 16'h4000)),
                                    16'($urandom_range(0, 16'h2000)), 32'h0});
            write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
            write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
            if (phase == 3)
            begin
                fork
                    random_points(150, 1'b1);
                    begin
                        @(posedge clk);
                        long_hold = 1'b1;
                        repeat (200) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join
            end
            else
                random_points(210, (phase % 2) == 0);
            drain();
        end

        done = 1'b1;
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### perspective_vertex_to_screen_core.f
src/pvs_pkg.sv
src/pvs_divider.sv
src/perspective_vertex_to_screen_core.sv
test/perspective_vertex_to_screen_core_test.sv
